@@ src/oversampled_sync_correlator_core_assert.svh @@
// Assertion macros shared by the correlator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef OVERSAMPLED_SYNC_CORRELATOR_CORE_ASSERT_SVH
`define OVERSAMPLED_SYNC_CORRELATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high
`define OSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset
`define OSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSC_ASSERT(label, clk, rst, prop, msg)
`define OSC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ src/osc_pkg.sv @@
// Shared constants, codes and types for the oversampled sync correlator.
// No dependencies; compiled before the interfaces and all modules.
package osc_pkg;

   // Sample and sync-word geometry
   localparam int SAMPLE_W        = 16;
   localparam int SYNC_W          = 64;
   localparam int DIST_W          = $clog2(SYNC_W + 1);
   localparam int THR_W           = 7;
   localparam int PAY_W           = 8;
   localparam int CHIPS_LOG2      = 4;                  // 16 chips per byte
   localparam int CNT_W           = PAY_W + CHIPS_LOG2;

   // Oversampling: phases wrap modulo OVERSAMPLE_RATE (2..32)
   localparam int OVERSAMPLE_RATE = 8;
   localparam int PHASE_W         = $clog2(OVERSAMPLE_RATE);
   localparam int CENTER_OFFSET   = 3 % OVERSAMPLE_RATE;

   // Running average window, a power of two so the mean is a shift
   localparam int AVG_LOG2        = 4;
   localparam int AVG_WINDOW      = 1 << AVG_LOG2;
   localparam int ACC_W           = SAMPLE_W + AVG_LOG2;

   // Search / lock modes
   localparam logic [1:0] MODE_LOOKING = 2'd0;
   localparam logic [1:0] MODE_UNDER   = 2'd1;
   localparam logic [1:0] MODE_LOCKED  = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD = 2'd2;

   localparam logic [THR_W-1:0] THRESH_RST  = 7'd4;
   localparam logic [PAY_W-1:0] PAYLOAD_RST = 8'd32;

   // Per-transaction commands from the control stage to the state stores
   typedef struct packed {
      logic upd;   // searching sample: write back and advance
      logic clr;   // end of packet: drop all stored history
   } osc_ctl_type;

endpackage

@@ src/osc_if.sv @@
// Valid/ready channel interfaces: sample input, chip output, register writes.
// Depends on osc_pkg for field widths.
interface osc_req_if;
   import osc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface osc_rsp_if;
   logic valid;
   logic ready;
   logic chip_bit;
   logic last_chip;
   modport source (output valid, output chip_bit, output last_chip, input ready);
   modport sink   (input valid, input chip_bit, input last_chip, output ready);
endinterface

interface osc_csr_if;
   import osc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SYNC_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/osc_csr.sv @@
// Configuration register file: sync pattern, match threshold, payload length.
// Depends on osc_pkg and osc_csr_if.
module osc_csr (
   input  logic                          clock,
   input  logic                          reset,
   osc_csr_if.sink                       csr_if,
   output logic [osc_pkg::SYNC_W-1:0]    sync_pattern,
   output logic [osc_pkg::THR_W-1:0]     match_threshold,
   output logic [osc_pkg::PAY_W-1:0]     payload_bytes
);
   import osc_pkg::*;

   logic [SYNC_W-1:0] sync_ff;
   logic [THR_W-1:0]  thresh_ff;
   logic [PAY_W-1:0]  payload_ff;

   assign csr_if.ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= '0;
         thresh_ff  <= THRESH_RST;
         payload_ff <= PAYLOAD_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_SYNC:    sync_ff    <= csr_if.data;
            CSR_THRESH:  thresh_ff  <= csr_if.data[THR_W-1:0];
            CSR_PAYLOAD: payload_ff <= csr_if.data[PAY_W-1:0];
            default: ;
         endcase
      end
   end

   assign sync_pattern    = sync_ff;
   assign match_threshold = thresh_ff;
   assign payload_bytes   = payload_ff;

endmodule

@@ src/osc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module osc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/osc_shift_unit.sv @@
// Per-phase 64-bit chip history in RAM, with valid bits for fast clearing,
// plus shift-in and Hamming distance against the sync pattern.
// Depends on osc_pkg and osc_ram.
module osc_shift_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  osc_pkg::osc_ctl_type          ctl,
   input  logic                          rd_en,
   input  logic [osc_pkg::PHASE_W-1:0]   rd_addr,
   input  logic [osc_pkg::PHASE_W-1:0]   s1_phase,
   input  logic                          chip,
   input  logic [osc_pkg::SYNC_W-1:0]    sync_pattern,
   output logic [osc_pkg::DIST_W-1:0]    ham_dist
);
   import osc_pkg::*;

   logic [OVERSAMPLE_RATE-1:0] vld_ff, vld_in;
   logic [SYNC_W-1:0]          rd_data;
   logic [SYNC_W-1:0]          cur_reg;
   logic [SYNC_W-1:0]          new_reg;

   function automatic logic [DIST_W-1:0] popcount(input logic [SYNC_W-1:0] v);
      logic [DIST_W-1:0] n;
      n = '0;
      for (int i = 0; i < SYNC_W; i++) begin
         n = n + DIST_W'(v[i]);
      end
      return n;
   endfunction

   osc_ram #(
      .WIDTH (SYNC_W),
      .DEPTH (OVERSAMPLE_RATE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.upd),
      .wr_addr (s1_phase),
      .wr_data (new_reg),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entries not written since the last clear read as zero
   assign cur_reg  = vld_ff[s1_phase] ? rd_data : '0;
   assign new_reg  = {cur_reg[SYNC_W-2:0], chip};
   assign ham_dist = popcount(new_reg ^ sync_pattern);

   // Valid bits
   always_comb begin
      vld_in = vld_ff;
      if (ctl.clr) begin
         vld_in = '0;
      end else if (ctl.upd) begin
         vld_in[s1_phase] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

endmodule

@@ src/osc_avg_unit.sv @@
// Sliding window of searching samples in RAM with a running sum; supplies
// the floor mean used as the slice level at lock.
// Depends on osc_pkg and osc_ram.
module osc_avg_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  osc_pkg::osc_ctl_type                 ctl,
   input  logic                                 rd_en,
   input  logic signed [osc_pkg::SAMPLE_W-1:0]  sample,
   output logic signed [osc_pkg::SAMPLE_W-1:0]  mean_level
);
   import osc_pkg::*;

   logic [AVG_LOG2-1:0]        ptr_ff, ptr_in;
   logic [AVG_LOG2-1:0]        rd_addr;
   logic signed [ACC_W-1:0]    accum_ff, accum_in;
   logic signed [ACC_W-1:0]    accum_sum;
   logic [AVG_WINDOW-1:0]      vld_ff, vld_in;
   logic [SAMPLE_W-1:0]        rd_data;
   logic [SAMPLE_W-1:0]        old_sample;

   osc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (AVG_WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.upd),
      .wr_addr (ptr_ff),
      .wr_data (sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read the slot the next transaction will overwrite
   always_comb begin
      if (ctl.clr) begin
         rd_addr = '0;
      end else if (ctl.upd) begin
         rd_addr = ptr_ff + 1'b1;
      end else begin
         rd_addr = ptr_ff;
      end
   end

   // Drop the oldest sample, add the new one
   assign old_sample = vld_ff[ptr_ff] ? rd_data : '0;
   assign accum_sum  = accum_ff
                     - {{AVG_LOG2{old_sample[SAMPLE_W-1]}}, old_sample}
                     + {{AVG_LOG2{sample[SAMPLE_W-1]}}, sample};
   // Floor division by the window; always fits the sample range
   assign mean_level = accum_sum[ACC_W-1:AVG_LOG2];

   always_comb begin
      ptr_in   = ptr_ff;
      accum_in = accum_ff;
      vld_in   = vld_ff;
      if (ctl.clr) begin
         ptr_in   = '0;
         accum_in = '0;
         vld_in   = '0;
      end else if (ctl.upd) begin
         ptr_in         = ptr_ff + 1'b1;
         accum_in       = accum_sum;
         vld_in[ptr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         accum_ff <= '0;
         vld_ff   <= '0;
      end else begin
         ptr_ff   <= ptr_in;
         accum_ff <= accum_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

@@ src/oversampled_sync_correlator_core.sv @@
// Oversampled sync-word correlator with bit synchronization, top level.
// Depends on osc_pkg, osc_if, osc_csr, osc_shift_unit, osc_avg_unit and the
// assertion macro header.
//
// Usage:
//   req_if carries one signed Q1.15 demodulator sample per transaction at the
//   oversampled rate. rsp_if carries a chip decision (chip_bit) with a
//   last_chip flag once the block has locked onto a sync word; most samples
//   produce no response. csr_if writes sync_pattern (0), match_threshold (1)
//   and payload_bytes (2); it is always ready and should only be used idle.
//   Throughput: one sample per clock unless a chip response is held. A sample's
//   state is read from the per-phase history RAM and the window RAM at
//   acceptance and written back when it leaves the working stage register;
//   its response then passes through the output register. Consecutive
//   samples touch different RAM entries, so no interlock is needed.
//   Reset (synchronous, active high) restores register defaults, clears all
//   history via valid bits and starts searching; no clearing pass is needed.
//   When rsp_if.ready is low the response is held in its output register;
//   samples that produce no response keep flowing, and the input stalls
//   only when a second chip would be produced.
`include "oversampled_sync_correlator_core_assert.svh"
module oversampled_sync_correlator_core (
   input  logic      clock,
   input  logic      reset,
   osc_req_if.sink   req_if,
   osc_rsp_if.source rsp_if,
   osc_csr_if.sink   csr_if
);
   import osc_pkg::*;

   // Configuration
   logic [SYNC_W-1:0] sync_pattern;
   logic [THR_W-1:0]  match_threshold;
   logic [PAY_W-1:0]  payload_bytes;

   // Working stage
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       req_accept;
   logic                       s1_emit, s1_fire, s1_search;
   logic                       chip;
   logic                       under_hit, enter_under, do_lock, end_pkt;
   logic [DIST_W-1:0]          ham_dist;
   logic signed [SAMPLE_W-1:0] mean_level;
   osc_ctl_type                ctl;

   // Architectural state
   logic [1:0]                 mode_ff, mode_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in, phase_next;
   logic [PHASE_W-1:0]         trans_ff, trans_in;
   logic [PHASE_W-1:0]         center_ff, center_in, center_calc;
   logic [CNT_W-1:0]           count_ff, count_in, count_next;
   logic [CNT_W-1:0]           total_chips;
   logic signed [SAMPLE_W-1:0] slice_ff, slice_in;

   // Center phase arithmetic, one bit wider than a phase
   logic [PHASE_W:0]           delta_raw, delta, half_sum, mid, off_sum;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_chip_ff, rsp_chip_in;
   logic rsp_last_ff, rsp_last_in;
   logic out_free;

   osc_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_if          (csr_if),
      .sync_pattern    (sync_pattern),
      .match_threshold (match_threshold),
      .payload_bytes   (payload_bytes)
   );

   osc_shift_unit u_shift (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .rd_en        (req_accept),
      .rd_addr      (phase_in),
      .s1_phase     (phase_ff),
      .chip         (chip),
      .sync_pattern (sync_pattern),
      .ham_dist     (ham_dist)
   );

   osc_avg_unit u_avg (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rd_en      (req_accept),
      .sample     (s1_sample_ff),
      .mean_level (mean_level)
   );

   // Handshake and stage control
   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign chip        = s1_sample_ff > slice_ff;
   assign s1_emit     = s1_valid_ff && (mode_ff == MODE_LOCKED) && (phase_ff == center_ff);
   assign s1_fire     = s1_valid_ff && (!s1_emit || out_free);
   assign s1_search   = s1_fire && (mode_ff != MODE_LOCKED);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_accept  = req_if.valid && req_if.ready;

   // Chip counting while locked
   assign count_next  = count_ff + 1'b1;
   assign total_chips = {payload_bytes, {CHIPS_LOG2{1'b0}}};
   assign end_pkt     = s1_fire && s1_emit && (count_next >= total_chips);

   // Sync detection while searching
   assign under_hit   = ham_dist <= match_threshold;
   assign enter_under = s1_search && (mode_ff != MODE_UNDER) && under_hit;
   assign do_lock     = s1_search && (mode_ff == MODE_UNDER) && !under_hit;

   assign ctl.upd = s1_search;
   assign ctl.clr = end_pkt;

   assign phase_next = (phase_ff == PHASE_W'(OVERSAMPLE_RATE - 1)) ? '0 : phase_ff + 1'b1;

   // Lock phase: transition + floor(delta / 2) + offset, all modulo the rate
   always_comb begin
      delta_raw = {1'b0, phase_ff} + (PHASE_W + 1)'(OVERSAMPLE_RATE) - {1'b0, trans_ff};
      delta     = (delta_raw >= (PHASE_W + 1)'(OVERSAMPLE_RATE))
                ? delta_raw - (PHASE_W + 1)'(OVERSAMPLE_RATE) : delta_raw;
      half_sum  = {1'b0, trans_ff} + (delta >> 1);
      mid       = (half_sum >= (PHASE_W + 1)'(OVERSAMPLE_RATE))
                ? half_sum - (PHASE_W + 1)'(OVERSAMPLE_RATE) : half_sum;
      off_sum   = mid + (PHASE_W + 1)'(CENTER_OFFSET);
      if (off_sum >= (PHASE_W + 1)'(OVERSAMPLE_RATE)) begin
         off_sum = off_sum - (PHASE_W + 1)'(OVERSAMPLE_RATE);
      end
      center_calc = off_sum[PHASE_W-1:0];
   end

   // Next state
   always_comb begin
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      trans_in  = trans_ff;
      center_in = center_ff;
      count_in  = count_ff;
      slice_in  = slice_ff;
      if (end_pkt) begin
         mode_in  = MODE_LOOKING;
         phase_in = '0;
         slice_in = slice_ff >>> 1;
      end else if (s1_fire) begin
         phase_in = phase_next;
         if (s1_emit) begin
            count_in = count_next;
         end
         if (enter_under) begin
            mode_in  = MODE_UNDER;
            trans_in = phase_ff;
         end else if (do_lock) begin
            mode_in   = MODE_LOCKED;
            center_in = center_calc;
            count_in  = '0;
            slice_in  = mean_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LOOKING;
         phase_ff  <= '0;
         trans_ff  <= '0;
         center_ff <= '0;
         count_ff  <= '0;
         slice_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         trans_ff  <= trans_in;
         center_ff <= center_in;
         count_ff  <= count_in;
         slice_ff  <= slice_in;
      end
   end

   // Working stage occupancy and sample capture
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_if.sample;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_chip_in  = rsp_chip_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_fire && s1_emit) begin
         rsp_valid_in = 1'b1;
         rsp_chip_in  = chip;
         rsp_last_in  = end_pkt;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_chip_ff <= rsp_chip_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.chip_bit  = rsp_chip_ff;
   assign rsp_if.last_chip = rsp_last_ff;

   // Checks
   `OSC_ASSERT(a_rsp_no_overwrite, clock, reset,
      (rsp_valid_ff && !rsp_if.ready) |-> !(s1_fire && s1_emit),
      "pending response overwritten")
   `OSC_ASSERT(a_end_restarts, clock, reset,
      end_pkt |=> (phase_ff == '0 && mode_ff == MODE_LOOKING),
      "packet end did not restart search at phase zero")
   `OSC_ASSERT(a_no_ram_clash, clock, reset,
      (req_accept && ctl.upd) |-> (phase_in != phase_ff),
      "history RAM read and write hit the same phase")
   `OSC_ASSERT(a_stall_holds, clock, reset,
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(phase_ff) && $stable(mode_ff)),
      "stalled stage changed state")

endmodule
